[design/bgc_pkg.sv]
`default_nettype none

package bgc_pkg;

   // counter widths
   localparam int TICK_COUNTER_WIDTH  = 16;
   localparam int CLICK_COUNTER_WIDTH = 4;

   // configuration port geometry
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CLICK_LIMIT_WIDTH = 4;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE_PRESS   = 3'd0,
      CSR_DEBOUNCE_RELEASE = 3'd1,
      CSR_CLICK_MAX        = 3'd2,
      CSR_SHORT_MAX        = 3'd3,
      CSR_LONG_MAX         = 3'd4,
      CSR_BURST_GAP        = 3'd5,
      CSR_CLICK_LIMIT      = 3'd6
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [CSR_DATA_WIDTH-1:0]    DEBOUNCE_PRESS_RESET   = 16'd2;
   localparam logic [CSR_DATA_WIDTH-1:0]    DEBOUNCE_RELEASE_RESET = 16'd2;
   localparam logic [CSR_DATA_WIDTH-1:0]    CLICK_MAX_RESET        = 16'd200;
   localparam logic [CSR_DATA_WIDTH-1:0]    SHORT_MAX_RESET        = 16'd500;
   localparam logic [CSR_DATA_WIDTH-1:0]    LONG_MAX_RESET         = 16'd1000;
   localparam logic [CSR_DATA_WIDTH-1:0]    BURST_GAP_RESET        = 16'd100;
   localparam logic [CLICK_LIMIT_WIDTH-1:0] CLICK_LIMIT_RESET      = 4'd5;

   // result event codes
   typedef enum logic [1:0] {
      EVENT_NONE  = 2'd0,
      EVENT_BURST = 2'd1,
      EVENT_SHORT = 2'd2,
      EVENT_LONG  = 2'd3
   } event_kind_type;

endpackage

`default_nettype wire

[design/button_gesture_classifier.sv]
`default_nettype none

// Classifies a sampled key level, one sample per transaction, into click bursts,
// short presses and long presses, and reports hold flags while the key is down.
// Every accepted sample yields exactly one result transaction in the next cycle.
// A sample can be accepted in every cycle: the whole update is a single pass of
// compares and counter increments into one result register, and req_stall is
// raised only while that register holds a result that the consumer is stalling.
// The user must write configuration registers via the csr_ port only while no
// sample is in flight, unenforced by the block; unused-index writes are dropped.
module button_gesture_classifier (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // sample channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_key_pressed,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [1:0]                                  rsp_event_kind,
   output logic [bgc_pkg::CLICK_COUNTER_WIDTH-1:0]     rsp_burst_clicks,
   output logic                                        rsp_hold_short_reached,
   output logic                                        rsp_hold_long_reached,
   output logic                                        rsp_click_registered,
   // configuration
   input  wire logic                                   csr_write_en,
   input  wire logic [bgc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [bgc_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // configuration registers
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] deb_press_ff;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] deb_release_ff;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] click_max_ff;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] short_max_ff;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] long_max_ff;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0] burst_gap_ff;
   logic [bgc_pkg::CLICK_LIMIT_WIDTH-1:0]  click_limit_ff;

   // gesture state
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0]  press_ff, press_in;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0]  release_ff, release_in;
   logic [bgc_pkg::CLICK_COUNTER_WIDTH-1:0] click_ff, click_in;

   // result register
   logic                                    rsp_valid_ff, rsp_valid_in;
   bgc_pkg::event_kind_type                 kind_ff, kind_in;
   logic [bgc_pkg::CLICK_COUNTER_WIDTH-1:0] burst_ff, burst_in;
   logic                                    hold_s_ff, hold_s_in;
   logic                                    hold_l_ff, hold_l_in;
   logic                                    clicked_ff, clicked_in;

   logic                                    accept;
   logic                                    burst_end;
   logic                                    burst_report;
   logic                                    classify;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0]  press_inc;
   logic [bgc_pkg::TICK_COUNTER_WIDTH-1:0]  release_inc;
   logic [bgc_pkg::CLICK_COUNTER_WIDTH-1:0] click_base;

   // handshake: stall only while a finished result is held back
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         deb_press_ff   <= bgc_pkg::DEBOUNCE_PRESS_RESET;
         deb_release_ff <= bgc_pkg::DEBOUNCE_RELEASE_RESET;
         click_max_ff   <= bgc_pkg::CLICK_MAX_RESET;
         short_max_ff   <= bgc_pkg::SHORT_MAX_RESET;
         long_max_ff    <= bgc_pkg::LONG_MAX_RESET;
         burst_gap_ff   <= bgc_pkg::BURST_GAP_RESET;
         click_limit_ff <= bgc_pkg::CLICK_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (bgc_pkg::csr_index_type'(csr_index))
            bgc_pkg::CSR_DEBOUNCE_PRESS:   deb_press_ff   <= csr_wdata;
            bgc_pkg::CSR_DEBOUNCE_RELEASE: deb_release_ff <= csr_wdata;
            bgc_pkg::CSR_CLICK_MAX:        click_max_ff   <= csr_wdata;
            bgc_pkg::CSR_SHORT_MAX:        short_max_ff   <= csr_wdata;
            bgc_pkg::CSR_LONG_MAX:         long_max_ff    <= csr_wdata;
            bgc_pkg::CSR_BURST_GAP:        burst_gap_ff   <= csr_wdata;
            bgc_pkg::CSR_CLICK_LIMIT:
               click_limit_ff <= csr_wdata[bgc_pkg::CLICK_LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // saturating increments
   assign press_inc   = (&press_ff) ? press_ff : press_ff + 1'b1;
   assign release_inc = (&release_ff) ? release_ff : release_ff + 1'b1;

   // burst check uses the release time from before this transaction
   assign burst_end    = release_ff > burst_gap_ff;
   assign burst_report = burst_end && (click_ff != '0) && (click_ff <= click_limit_ff);
   assign click_base   = burst_end ? '0 : click_ff;
   assign classify     = !req_key_pressed && (press_ff > deb_press_ff)
                         && (release_inc >= deb_release_ff);

   // hold and release checks
   always_comb begin
      press_in   = press_ff;
      release_in = release_ff;
      click_in   = click_base;
      kind_in    = burst_report ? bgc_pkg::EVENT_BURST : bgc_pkg::EVENT_NONE;
      burst_in   = burst_report ? click_ff : '0;
      hold_s_in  = 1'b0;
      hold_l_in  = 1'b0;
      clicked_in = 1'b0;
      if (req_key_pressed) begin
         press_in   = press_inc;
         release_in = '0;
         hold_s_in  = press_inc > click_max_ff;
         hold_l_in  = (press_inc > click_max_ff) && (press_inc > short_max_ff);
      end else begin
         release_in = release_inc;
         if (classify) begin
            press_in = '0;
            priority if (press_ff < short_max_ff && press_ff > click_max_ff) begin
               kind_in = bgc_pkg::EVENT_SHORT;
            end else if (press_ff < long_max_ff && press_ff > short_max_ff) begin
               kind_in = bgc_pkg::EVENT_LONG;
            end else if (press_ff < click_max_ff) begin
               click_in   = (&click_base) ? click_base : click_base + 1'b1;
               clicked_in = 1'b1;
            end else begin
               // duration on a threshold or beyond the long bound: no event
            end
         end
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff     <= '0;
         release_ff   <= '0;
         click_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            press_ff   <= press_in;
            release_ff <= release_in;
            click_ff   <= click_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= kind_in;
         burst_ff   <= burst_in;
         hold_s_ff  <= hold_s_in;
         hold_l_ff  <= hold_l_in;
         clicked_ff <= clicked_in;
      end
   end

   // result ports
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_event_kind         = kind_ff;
   assign rsp_burst_clicks       = burst_ff;
   assign rsp_hold_short_reached = hold_s_ff;
   assign rsp_hold_long_reached  = hold_l_ff;
   assign rsp_click_registered   = clicked_ff;

endmodule

`default_nettype wire

[design/bgc_checker.sv]
`default_nettype none

module bgc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [1:0]                          rsp_event_kind,
   input wire logic [bgc_pkg::CLICK_COUNTER_WIDTH-1:0] rsp_burst_clicks,
   input wire logic                                rsp_hold_short_reached,
   input wire logic                                rsp_hold_long_reached,
   input wire logic                                rsp_click_registered
);

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds its event kind, burst clicks and click flag
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_burst_clicks) && $stable(rsp_click_registered))
      else $error("stalled result changed");

   // long hold implies short hold
   a_hold_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hold_long_reached |-> rsp_hold_short_reached)
      else $error("long hold without short hold");

   // a burst report always carries its clicks, and burst clicks need an event
   a_burst_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == bgc_pkg::EVENT_BURST
         || rsp_burst_clicks != '0)
      |-> rsp_burst_clicks != '0 && rsp_event_kind != bgc_pkg::EVENT_NONE)
      else $error("burst report inconsistent");

   // a counted click happens on release and excludes press events and holds
   a_click_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_click_registered
      |-> rsp_event_kind != bgc_pkg::EVENT_SHORT
         && rsp_event_kind != bgc_pkg::EVENT_LONG
         && !rsp_hold_short_reached && !rsp_hold_long_reached)
      else $error("click registered with press event or hold");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);

`default_nettype wire
